// ===== rtl/rmq_pkg.sv =====
// Shared widths, types and helpers for the matrix-to-quaternion pipeline.
`timescale 1ns / 1ps

package rmq_pkg;

    localparam int Q_W    = 16;   // Q2.14 fields
    localparam int EXT_W  = 20;   // sums of three entries plus one
    localparam int NUM_W  = 17;   // off-diagonal sum or difference
    localparam int RAD_W  = 30;   // radicand after the 2^12 scale
    localparam int RT_W   = RAD_W / 2;
    localparam int QUO_W  = 15;   // quotient bits below saturation
    localparam int DN_W   = 29;   // rounded dividend
    localparam int FRAC_SH = 12;
    localparam int N_LANE = 4;
    localparam int Q_ONE  = 16384;

    localparam logic signed [Q_W-1:0] Q_MAX = 16'sh7FFF;
    localparam logic signed [Q_W-1:0] Q_MIN = 16'sh8000;

    // Which component comes straight from the root.
    typedef enum logic [1:0] {
        DOM_X = 2'd0,
        DOM_Y = 2'd1,
        DOM_Z = 2'd2,
        DOM_W = 2'd3
    } dom_t;

    function automatic logic signed [EXT_W-1:0] sext(input logic signed [Q_W-1:0] v);
        sext = {{(EXT_W-Q_W){v[Q_W-1]}}, v};
    endfunction

endpackage

// ===== rtl/rmq_sqrt.sv =====
// Pipelined integer square root, one result bit per stage.
`timescale 1ns / 1ps

module rmq_sqrt
    import rmq_pkg::*;
#(
    parameter int PW = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [RAD_W-1:0]  rad,
    input  logic [PW-1:0]     in_pay,
    output logic              out_valid,
    output logic [RT_W-1:0]   root,
    output logic [PW-1:0]     out_pay
);

    logic [RAD_W-1:0] rem_reg  [0:RT_W];
    logic [RT_W-1:0]  root_reg [0:RT_W];
    logic [PW-1:0]    pay_reg  [0:RT_W];
    logic             vld_reg  [0:RT_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0]  <= rad;
        root_reg[0] <= '0;
        pay_reg[0]  <= in_pay;
    end

    for (genvar s = 0; s < RT_W; s++)
    begin : g_stage
        localparam int B = RT_W - 1 - s;
        logic [RAD_W-1:0] term;
        logic             take;

        // (r + 2^b)^2 - r^2 with r holding only bits above b
        assign term = (RAD_W'(root_reg[s]) << (B + 1)) | (RAD_W'(1) << (2 * B));
        assign take = (rem_reg[s] >= term);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[s+1] <= 1'b0;
            end
            else
            begin
                vld_reg[s+1] <= vld_reg[s];
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[s+1]  <= take ? (rem_reg[s] - term) : rem_reg[s];
            root_reg[s+1] <= take ? (root_reg[s] | (RT_W'(1) << B)) : root_reg[s];
            pay_reg[s+1]  <= pay_reg[s];
        end
    end

    assign out_valid = vld_reg[RT_W];
    assign root      = root_reg[RT_W];
    assign out_pay   = pay_reg[RT_W];

endmodule

// ===== rtl/rmq_div.sv =====
// Four-lane pipelined rounded divide by the root, with saturation.
`timescale 1ns / 1ps

module rmq_div
    import rmq_pkg::*;
#(
    parameter int PW = 2
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic [RT_W-1:0]         den,
    input  logic signed [NUM_W-1:0] num [N_LANE],
    input  logic [PW-1:0]           in_pay,
    output logic                    out_valid,
    output logic [RT_W-1:0]         out_den,
    output logic signed [Q_W-1:0]   quo [N_LANE],
    output logic [PW-1:0]           out_pay
);

    logic [DN_W-1:0]  prep_rem [N_LANE];
    logic             prep_ov  [N_LANE];
    logic             prep_neg [N_LANE];

    logic [DN_W-1:0]  rem_reg [0:QUO_W][N_LANE];
    logic [QUO_W-1:0] q_reg   [0:QUO_W][N_LANE];
    logic             ov_reg  [0:QUO_W][N_LANE];
    logic             neg_reg [0:QUO_W][N_LANE];
    logic [RT_W-1:0]  den_reg [0:QUO_W];
    logic [PW-1:0]    pay_reg [0:QUO_W];
    logic             vld_reg [0:QUO_W];

    logic                  out_vld_reg;
    logic [RT_W-1:0]       out_den_reg;
    logic signed [Q_W-1:0] quo_reg [N_LANE];
    logic [PW-1:0]         out_pay_reg;

    // dividend = |n| * 2^12 + den/2, so a floor divide rounds half away from zero
    always_comb
    begin
        logic [NUM_W-1:0] mag;
        for (int l = 0; l < N_LANE; l++)
        begin
            mag = num[l][NUM_W-1] ? (~num[l] + 1'b1) : num[l];
            prep_rem[l] = (DN_W'(mag) << FRAC_SH) + DN_W'(den >> 1);
            prep_ov[l]  = ({1'b0, prep_rem[l]} >= ((DN_W + 1)'(den) << QUO_W));
            prep_neg[l] = num[l][NUM_W-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        den_reg[0] <= den;
        pay_reg[0] <= in_pay;
        for (int l = 0; l < N_LANE; l++)
        begin
            rem_reg[0][l] <= prep_rem[l];
            q_reg[0][l]   <= '0;
            ov_reg[0][l]  <= prep_ov[l];
            neg_reg[0][l] <= prep_neg[l];
        end
    end

    for (genvar s = 0; s < QUO_W; s++)
    begin : g_stage
        localparam int B = QUO_W - 1 - s;
        logic [DN_W-1:0] dsh;

        assign dsh = DN_W'(den_reg[s]) << B;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[s+1] <= 1'b0;
            end
            else
            begin
                vld_reg[s+1] <= vld_reg[s];
            end
        end

        always_ff @(posedge clk)
        begin
            den_reg[s+1] <= den_reg[s];
            pay_reg[s+1] <= pay_reg[s];
            for (int l = 0; l < N_LANE; l++)
            begin
                if (rem_reg[s][l] >= dsh)
                begin
                    rem_reg[s+1][l] <= rem_reg[s][l] - dsh;
                    q_reg[s+1][l]   <= q_reg[s][l] | (QUO_W'(1) << B);
                end
                else
                begin
                    rem_reg[s+1][l] <= rem_reg[s][l];
                    q_reg[s+1][l]   <= q_reg[s][l];
                end
                ov_reg[s+1][l]  <= ov_reg[s][l];
                neg_reg[s+1][l] <= neg_reg[s][l];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg <= vld_reg[QUO_W];
        end
    end

    always_ff @(posedge clk)
    begin
        out_den_reg <= den_reg[QUO_W];
        out_pay_reg <= pay_reg[QUO_W];
        for (int l = 0; l < N_LANE; l++)
        begin
            priority if (den_reg[QUO_W] == '0)
            begin
                quo_reg[l] <= '0;
            end
            else if (ov_reg[QUO_W][l])
            begin
                quo_reg[l] <= neg_reg[QUO_W][l] ? Q_MIN : Q_MAX;
            end
            else if (neg_reg[QUO_W][l])
            begin
                quo_reg[l] <= -$signed({1'b0, q_reg[QUO_W][l]});
            end
            else
            begin
                quo_reg[l] <= $signed({1'b0, q_reg[QUO_W][l]});
            end
        end
    end

    assign out_valid = out_vld_reg;
    assign out_den   = out_den_reg;
    assign quo       = quo_reg;
    assign out_pay   = out_pay_reg;

endmodule

// ===== rtl/rotation_matrix_to_quaternion.sv =====
// Rotation matrix (Q2.14) to unit quaternion (Q2.14) by Shoemake's method.
//
// Fully pipelined: one matrix may be started every clock cycle and busy is
// always low. Each transaction returns one quaternion on qx/qy/qz/qw with a
// one-cycle done strobe after passing through an input register, a 16-stage
// square root (a load register, then one root bit per stage for the 15 root
// bits), a 17-stage rounded divide (setup, one quotient bit per stage for the
// 15 quotient bits, and saturation) run on four lanes, and an output register.
// Results cannot be held off; the receiver must take each one in its strobe
// cycle.
`timescale 1ns / 1ps

module rotation_matrix_to_quaternion
    import rmq_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic signed [Q_W-1:0] m00,
    input  logic signed [Q_W-1:0] m01,
    input  logic signed [Q_W-1:0] m02,
    input  logic signed [Q_W-1:0] m10,
    input  logic signed [Q_W-1:0] m11,
    input  logic signed [Q_W-1:0] m12,
    input  logic signed [Q_W-1:0] m20,
    input  logic signed [Q_W-1:0] m21,
    input  logic signed [Q_W-1:0] m22,
    output logic                  done,
    output logic signed [Q_W-1:0] qx,
    output logic signed [Q_W-1:0] qy,
    output logic signed [Q_W-1:0] qz,
    output logic signed [Q_W-1:0] qw
);

    localparam int LAT  = 5 + RT_W + QUO_W;
    localparam int SQ_PW = 2 + N_LANE * NUM_W;
    localparam int DV_PW = 2;

    logic                  vld_a_reg;
    logic signed [Q_W-1:0] a00_reg, a01_reg, a02_reg;
    logic signed [Q_W-1:0] a10_reg, a11_reg, a12_reg;
    logic signed [Q_W-1:0] a20_reg, a21_reg, a22_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_a_reg <= 1'b0;
        end
        else
        begin
            vld_a_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        a00_reg <= m00; a01_reg <= m01; a02_reg <= m02;
        a10_reg <= m10; a11_reg <= m11; a12_reg <= m12;
        a20_reg <= m20; a21_reg <= m21; a22_reg <= m22;
    end

    // Pick the dominant component, its radicand and the four numerators.
    logic signed [EXT_W-1:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;
    logic signed [EXT_W-1:0] tr, rad_s;
    logic signed [EXT_W-1:0] n_a, n_b, n_c;
    logic signed [NUM_W-1:0] nx, ny, nz, nw;
    logic                    sel_y, sel_z;
    logic signed [Q_W-1:0]   diag_max;
    dom_t                    dom;
    logic [RAD_W-1:0]        rad;

    always_comb
    begin
        e00 = sext(a00_reg); e01 = sext(a01_reg); e02 = sext(a02_reg);
        e10 = sext(a10_reg); e11 = sext(a11_reg); e12 = sext(a12_reg);
        e20 = sext(a20_reg); e21 = sext(a21_reg); e22 = sext(a22_reg);
        tr  = e00 + e11 + e22;

        // ties keep the lower axis
        sel_y    = (a11_reg > a00_reg);
        diag_max = sel_y ? a11_reg : a00_reg;
        sel_z    = (a22_reg > diag_max);

        priority if (!tr[EXT_W-1] && tr != '0)
            dom = DOM_W;
        else if (sel_z)
            dom = DOM_Z;
        else if (sel_y)
            dom = DOM_Y;
        else
            dom = DOM_X;

        n_a = e12 - e21;
        n_b = e20 - e02;
        n_c = e01 - e10;

        unique case (dom)
            DOM_W:
            begin
                rad_s = tr + EXT_W'(Q_ONE);
                nx = n_a[NUM_W-1:0];
                ny = n_b[NUM_W-1:0];
                nz = n_c[NUM_W-1:0];
                nw = '0;
            end
            DOM_X:
            begin
                rad_s = e00 - (e11 + e22) + EXT_W'(Q_ONE);
                nx = '0;
                ny = NUM_W'(e01 + e10);
                nz = NUM_W'(e02 + e20);
                nw = n_a[NUM_W-1:0];
            end
            DOM_Y:
            begin
                rad_s = e11 - (e22 + e00) + EXT_W'(Q_ONE);
                nx = NUM_W'(e10 + e01);
                ny = '0;
                nz = NUM_W'(e12 + e21);
                nw = n_b[NUM_W-1:0];
            end
            DOM_Z:
            begin
                rad_s = e22 - (e00 + e11) + EXT_W'(Q_ONE);
                nx = NUM_W'(e20 + e02);
                ny = NUM_W'(e21 + e12);
                nz = '0;
                nw = n_c[NUM_W-1:0];
            end
            default:
            begin
                rad_s = '0;
                nx = '0;
                ny = '0;
                nz = '0;
                nw = '0;
            end
        endcase

        // negative radicand clamps to zero; scale by 2^12 for the root
        rad = rad_s[EXT_W-1] ? '0 : (RAD_W'(rad_s[EXT_W-2:0]) << FRAC_SH);
    end

    logic             sq_vld;
    logic [RT_W-1:0]  sq_root;
    logic [SQ_PW-1:0] sq_pay;

    rmq_sqrt #(
        .PW (SQ_PW)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vld_a_reg),
        .rad       (rad),
        .in_pay    ({dom, nw, nz, ny, nx}),
        .out_valid (sq_vld),
        .root      (sq_root),
        .out_pay   (sq_pay)
    );

    logic signed [NUM_W-1:0] dv_num [N_LANE];
    logic                    dv_vld;
    logic [RT_W-1:0]         dv_den;
    logic signed [Q_W-1:0]   dv_quo [N_LANE];
    logic [DV_PW-1:0]        dv_pay;

    always_comb
    begin
        for (int l = 0; l < N_LANE; l++)
        begin
            dv_num[l] = sq_pay[l*NUM_W +: NUM_W];
        end
    end

    rmq_div #(
        .PW (DV_PW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sq_vld),
        .den       (sq_root),
        .num       (dv_num),
        .in_pay    (sq_pay[SQ_PW-1 -: DV_PW]),
        .out_valid (dv_vld),
        .out_den   (dv_den),
        .quo       (dv_quo),
        .out_pay   (dv_pay)
    );

    dom_t                  dv_dom;
    logic signed [Q_W-1:0] root_q;
    logic                  done_reg;
    logic signed [Q_W-1:0] qx_reg, qy_reg, qz_reg, qw_reg;
    logic signed [Q_W-1:0] qx_next, qy_next, qz_next, qw_next;

    always_comb
    begin
        dv_dom  = dom_t'(dv_pay);
        root_q  = $signed(Q_W'(dv_den));
        qx_next = (dv_dom == DOM_X) ? root_q : dv_quo[0];
        qy_next = (dv_dom == DOM_Y) ? root_q : dv_quo[1];
        qz_next = (dv_dom == DOM_Z) ? root_q : dv_quo[2];
        qw_next = (dv_dom == DOM_W) ? root_q : dv_quo[3];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= dv_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        qx_reg <= qx_next;
        qy_reg <= qy_next;
        qz_reg <= qz_next;
        qw_reg <= qw_next;
    end

    assign busy = 1'b0;
    assign done = done_reg;
    assign qx   = qx_reg;
    assign qy   = qy_reg;
    assign qz   = qz_reg;
    assign qw   = qw_reg;

    // every transaction comes out after the fixed latency
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("transaction did not complete after pipeline latency");

    // a zero root zeroes the whole quaternion
    a_zero_root: assert property (@(posedge clk) disable iff (!rst_n)
        (dv_vld && dv_den == '0) |=> (qx == '0 && qy == '0 && qz == '0 && qw == '0))
        else $error("zero root produced a nonzero component");

    // the dominant component is never negative; checked here for w
    a_dom_sign: assert property (@(posedge clk) disable iff (!rst_n)
        (dv_vld && dv_dom == DOM_W) |=> !qw[Q_W-1])
        else $error("dominant w came out negative");

endmodule
